// ===== rtl/core/dnpp_pkg.sv =====
// ----------------------------------------------------------------------------
// Delimited number packet parser package
// Character codes, field widths, result layout and the power-of-ten table.
// ----------------------------------------------------------------------------
package dnpp_pkg;

    localparam int MAX_FIELD_CHARS = 16;
    localparam int CNT_W           = $clog2(MAX_FIELD_CHARS + 1);

    localparam int BYTE_W      = 8;
    localparam int MAG_W       = 54;
    localparam int MANT_W      = 55;
    localparam int DEC_W       = 5;
    localparam int NUM_HELD    = 3;
    localparam int POS_W       = 2;
    localparam int IN_TDATA_W  = 8;
    localparam int RESULT_W    = 3 * (MANT_W + DEC_W) + 1;
    localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    localparam logic [MAG_W-1:0] MAX_MAG  = 54'd9999999999999999;
    localparam logic [DEC_W-1:0] MAX_FRAC = 5'd16;

    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_A     = 8'h61;
    localparam logic [BYTE_W-1:0] CH_D     = 8'h64;
    localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;

    localparam logic [POS_W-1:0] POS_LAST = 2'd3;

    // Packed from the lowest bit up: line angle first, crossing flag last
    typedef struct packed {
        logic              crosses_line;
        logic [DEC_W-1:0]  chord_decimals;
        logic [MANT_W-1:0] chord_mantissa;
        logic [DEC_W-1:0]  avoid_angle_decimals;
        logic [MANT_W-1:0] avoid_angle_mantissa;
        logic [DEC_W-1:0]  line_angle_decimals;
        logic [MANT_W-1:0] line_angle_mantissa;
    } t_result;

    function automatic logic [MAG_W-1:0] pow10(input logic [DEC_W-1:0] n);
        logic [MAG_W-1:0] v;
        case (n)
            5'd0:    v = 54'd1;
            5'd1:    v = 54'd10;
            5'd2:    v = 54'd100;
            5'd3:    v = 54'd1000;
            5'd4:    v = 54'd10000;
            5'd5:    v = 54'd100000;
            5'd6:    v = 54'd1000000;
            5'd7:    v = 54'd10000000;
            5'd8:    v = 54'd100000000;
            5'd9:    v = 54'd1000000000;
            5'd10:   v = 54'd10000000000;
            5'd11:   v = 54'd100000000000;
            5'd12:   v = 54'd1000000000000;
            5'd13:   v = 54'd10000000000000;
            5'd14:   v = 54'd100000000000000;
            5'd15:   v = 54'd1000000000000000;
            5'd16:   v = 54'd10000000000000000;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/delimited_number_packet_parser.sv =====
// ----------------------------------------------------------------------------
// Delimited number packet parser
// Parses tagged decimal numbers a, b, c, d into one packet result.
// ----------------------------------------------------------------------------
// The parser takes one byte per clock cycle while tready is high and updates
// its number state in the same cycle; a byte is never held back by the parsing
// itself. Each packet result is registered when the tag d byte is taken.
// Results leave through an output register backed by one skid entry, so the
// slave side keeps taking bytes while a result waits; tready drops only when
// both of those hold a result that has not yet been taken.
module delimited_number_packet_parser (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [7:0] rx_byte
    input  logic [dnpp_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [54:0] line_angle_mantissa, [59:55] line_angle_decimals,
    // [114:60] avoid_angle_mantissa, [119:115] avoid_angle_decimals,
    // [174:120] chord_mantissa, [179:175] chord_decimals,
    // [180] crosses_line, [183:181] zero
    output logic [dnpp_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);

    import dnpp_pkg::*;

    // Parser state
    logic [POS_W-1:0]  r_field_pos,  n_field_pos;
    logic [CNT_W-1:0]  r_char_count, n_char_count;
    logic [MAG_W-1:0]  r_acc,        n_acc;
    logic [DEC_W-1:0]  r_frac,       n_frac;
    logic              r_point,      n_point;
    logic              r_digit,      n_digit;
    logic              r_minus,      n_minus;
    logic              r_bad,        n_bad;

    logic [MANT_W-1:0] r_held_mant [NUM_HELD];
    logic [DEC_W-1:0]  r_held_dec  [NUM_HELD];

    // Output register and skid entry
    logic              r_out_valid;
    logic              r_skid_valid;
    t_result           r_out;
    t_result           r_skid;

    logic [BYTE_W-1:0] rx;
    logic              s_accept;
    logic              out_take;
    logic              is_tag;
    logic              is_digit;
    logic [POS_W-1:0]  tag;
    logic              hold_wr;
    logic              emit;
    logic [MAG_W+3:0]  acc_next;
    logic              digit_over;
    logic [MANT_W-1:0] signed_mant;
    logic              crosses;
    t_result           new_result;

    assign rx       = i_s_axis_tdata[BYTE_W-1:0];
    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign out_take = r_out_valid && i_m_axis_tready;
    // Tag letters a to d are contiguous, so the low bits give the position
    assign tag      = rx[POS_W-1:0] - CH_A[POS_W-1:0];

    // Ten times the magnitude plus the new digit, with headroom for the check
    assign acc_next = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                    + {{(MAG_W+4-4){1'b0}}, rx[3:0]};
    assign digit_over = (acc_next > {4'b0000, MAX_MAG})
                     || (r_point && (r_frac >= MAX_FRAC));

    assign signed_mant = r_minus ? ({MANT_W{1'b0}} - {1'b0, r_acc}) : {1'b0, r_acc};

    assign crosses = (!r_minus || (r_acc == '0)) && (r_frac <= MAX_FRAC)
                  && (r_acc == pow10(r_frac));

    always_comb begin
        is_tag   = rx inside {[CH_A:CH_D]};
        is_digit = rx inside {[CH_0:CH_9]};

        n_field_pos  = r_field_pos;
        n_char_count = r_char_count;
        n_acc        = r_acc;
        n_frac       = r_frac;
        n_point      = r_point;
        n_digit      = r_digit;
        n_minus      = r_minus;
        n_bad        = r_bad;
        hold_wr      = 1'b0;
        emit         = 1'b0;

        if (s_accept) begin
            if ((rx == CH_LF) || (rx == CH_CR)) begin
                n_field_pos  = '0;
                n_char_count = '0;
                n_acc        = '0;
                n_frac       = '0;
                n_point      = 1'b0;
                n_digit      = 1'b0;
                n_minus      = 1'b0;
                n_bad        = 1'b0;
            end else if (is_tag) begin
                // Every tag closes the number; only the position may survive
                n_char_count = '0;
                n_acc        = '0;
                n_frac       = '0;
                n_point      = 1'b0;
                n_digit      = 1'b0;
                n_minus      = 1'b0;
                n_bad        = 1'b0;
                if (r_bad || !r_digit || (tag != r_field_pos)) begin
                    n_field_pos = '0;
                end else if (tag != POS_LAST) begin
                    hold_wr     = 1'b1;
                    n_field_pos = r_field_pos + 1'b1;
                end else begin
                    emit        = 1'b1;
                    n_field_pos = '0;
                end
            end else if (r_char_count >= CNT_W'(MAX_FIELD_CHARS)) begin
                // Number too long: drop the byte and restart
                n_field_pos  = '0;
                n_char_count = '0;
                n_acc        = '0;
                n_frac       = '0;
                n_point      = 1'b0;
                n_digit      = 1'b0;
                n_minus      = 1'b0;
                n_bad        = 1'b0;
            end else begin
                n_char_count = r_char_count + 1'b1;
                if (is_digit) begin
                    if (digit_over) begin
                        n_bad = 1'b1;
                    end else begin
                        n_acc   = acc_next[MAG_W-1:0];
                        n_digit = 1'b1;
                        if (r_point) begin
                            n_frac = r_frac + 1'b1;
                        end
                    end
                end else if (rx == CH_DOT) begin
                    if (r_point) begin
                        n_bad = 1'b1;
                    end
                    n_point = 1'b1;
                end else if (((rx == CH_MINUS) || (rx == CH_PLUS))
                             && (r_char_count == '0)) begin
                    if (rx == CH_MINUS) begin
                        n_minus = 1'b1;
                    end
                end else begin
                    n_bad = 1'b1;
                end
            end
        end
    end

    always_comb begin
        new_result.line_angle_mantissa  = r_held_mant[0];
        new_result.line_angle_decimals  = r_held_dec[0];
        new_result.avoid_angle_mantissa = r_held_mant[1];
        new_result.avoid_angle_decimals = r_held_dec[1];
        new_result.chord_mantissa       = r_held_mant[2];
        new_result.chord_decimals       = r_held_dec[2];
        new_result.crosses_line         = crosses;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_pos  <= '0;
            r_char_count <= '0;
            r_acc        <= '0;
            r_frac       <= '0;
            r_point      <= 1'b0;
            r_digit      <= 1'b0;
            r_minus      <= 1'b0;
            r_bad        <= 1'b0;
        end else begin
            r_field_pos  <= n_field_pos;
            r_char_count <= n_char_count;
            r_acc        <= n_acc;
            r_frac       <= n_frac;
            r_point      <= n_point;
            r_digit      <= n_digit;
            r_minus      <= n_minus;
            r_bad        <= n_bad;
        end
    end

    // Held values survive a parser restart
    always_ff @(posedge i_clk) begin
        if (hold_wr) begin
            r_held_mant[r_field_pos] <= signed_mant;
            r_held_dec[r_field_pos]  <= r_frac;
        end
    end

    // Skid is only filled while the head is stalled, so order is kept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid) begin
                r_out_valid <= emit;
            end else if (out_take) begin
                r_out_valid  <= r_skid_valid || emit;
                r_skid_valid <= 1'b0;
            end else if (emit) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (emit) begin
                r_out <= new_result;
            end
        end else if (emit) begin
            r_skid <= new_result;
        end
    end

    assign o_s_axis_tready = !r_skid_valid;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W-RESULT_W){1'b0}}, r_out};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_char_count <= CNT_W'(MAX_FIELD_CHARS))
        else $error("character count beyond field limit");

    a_frac_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frac <= MAX_FRAC)
        else $error("fraction digit count beyond limit");

    a_skid_behind_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a result while the output register is empty");

    a_line_end_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && ((rx == CH_LF) || (rx == CH_CR)))
        |=> ((r_field_pos == '0) && (r_char_count == '0)))
        else $error("line end did not restart the parser");
`endif

endmodule
